FILE: rtl/core/clcp_pkg.sv
// Package for the command line checksum parser: codes, character constants,
// line limits and small decode functions. No dependencies.
package clcp_pkg;

    // Line length (bytes before the newline) at which the line is flagged as too long
    localparam int MAX_LINE = 255;
    localparam int MIN_LINE = 6;
    localparam int LPOS_W   = $clog2(MAX_LINE + 1);

    // Line positions where a digit run may start
    localparam int POS_DIGITS_O   = 2;
    localparam int POS_DIGITS_XYZ = 3;
    localparam int POS_DIGITS_E   = 4;
    localparam int POS_FIRST_RUN  = 2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NO_START  = 3'd2,
        ST_NO_STAR   = 3'd3,
        ST_BAD_SUM   = 3'd4,
        ST_BAD_INDEX = 3'd5,
        ST_TOO_LONG  = 3'd6
    } t_status;

    typedef logic [4:0] t_target;

    // Parameter targets
    localparam t_target TGT_NOP     = 5'd0;
    localparam t_target TGT_E_OFS   = 5'd1;
    localparam t_target TGT_E_GAIN  = 5'd2;
    localparam t_target TGT_X_BASE  = 5'd5;
    localparam t_target TGT_Y_BASE  = 5'd13;
    localparam t_target TGT_Z_E     = 5'd21;
    localparam t_target TGT_Z_F     = 5'd22;
    localparam t_target TGT_OUTPUT  = 5'd23;
    localparam t_target TGT_SAVE    = 5'd24;
    localparam t_target TGT_DUMP    = 5'd25;

    // Characters
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UG     = 8'h47;
    localparam logic [7:0] CH_UI     = 8'h49;
    localparam logic [7:0] CH_UL     = 8'h4C;
    localparam logic [7:0] CH_UO     = 8'h4F;
    localparam logic [7:0] CH_UP     = 8'h50;
    localparam logic [7:0] CH_UW     = 8'h57;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_UY     = 8'h59;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;

    localparam logic [3:0] SLOT_NONE = 4'd8;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    // Decode one hex character, either case
    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        case (c) inside
            [CH_0:CH_9]:   h.val = 4'(c - CH_0);
            [CH_UA:CH_UF]: h.val = 4'(c - CH_UA + 8'd10);
            [CH_LA:CH_LF]: h.val = 4'(c - CH_LA + 8'd10);
            default:       h.ok  = 1'b0;
        endcase
        return h;
    endfunction

    // Line position where the value digits of a command begin; zero if none
    function automatic logic [LPOS_W-1:0] digit_start(input logic [7:0] letter);
        logic [LPOS_W-1:0] pos;
        case (letter)
            CH_UO:               pos = LPOS_W'(POS_DIGITS_O);
            CH_UE:               pos = LPOS_W'(POS_DIGITS_E);
            CH_UX, CH_UY, CH_UZ: pos = LPOS_W'(POS_DIGITS_XYZ);
            default:             pos = '0;
        endcase
        return pos;
    endfunction

    // Axis parameter slot in the order P I G A O L E F
    function automatic logic [3:0] axis_slot(input logic [7:0] c);
        logic [3:0] s;
        case (c)
            CH_UP:   s = 4'd0;
            CH_UI:   s = 4'd1;
            CH_UG:   s = 4'd2;
            CH_UA:   s = 4'd3;
            CH_UO:   s = 4'd4;
            CH_UL:   s = 4'd5;
            CH_UE:   s = 4'd6;
            CH_UF:   s = 4'd7;
            default: s = SLOT_NONE;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/core/clcp_if.sv
// Valid/ready channel interfaces for the command line checksum parser.
// Depends on nothing but the field widths listed here.
interface clcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface clcp_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  target;
    logic [31:0] value;

    modport source (output valid, output status, output target, output value, input ready);
    modport sink   (input valid, input status, input target, input value, output ready);
endinterface

FILE: rtl/core/command_line_checksum_parser_core.sv
// Command line checksum parser: byte input register, per-line state and
// a result register. Depends on clcp_pkg and the interfaces in clcp_if.sv.
//
// Usage:
//   i_rx carries received bytes, one per transfer. A line is '$' body '*'
//   plus two hex digits, closed by a newline. Every byte other than newline
//   only updates the line state and gives no result.
//   o_res carries one result per newline: status, target and value.
//   A byte is held in the input register and processed there; a newline's
//   result is then loaded into the result register, which drives o_res.
//   Throughput: one byte per cycle while no newline waits, set by the
//   combinational update of the line state (XOR, digit accumulator
//   multiply-by-ten and saturation).
//   Ordinary bytes pass through even while a result waits on o_res.
//   When the receiver stalls and a result is held, a following newline
//   waits in the input register and i_rx.ready drops until the held
//   result is taken.
//   Reset (i_rst_n low, synchronous) empties both registers and clears all
//   line state, so the next byte is line position zero.
module command_line_checksum_parser_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clcp_rx_if.sink           i_rx,
    clcp_res_if.source        o_res
);

    localparam int LW = clcp_pkg::LPOS_W;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Line state
    logic [LW-1:0] r_lpos, n_lpos;
    logic [7:0]    r_xor, n_xor;
    logic [7:0]    r_rb  [0:2];
    logic [7:0]    n_rb  [0:2];
    logic [7:0]    r_cmd [0:2];
    logic [7:0]    n_cmd [0:2];
    logic [31:0]   r_acc, n_acc;
    logic          r_dact, n_dact;
    logic          r_start, n_start;

    // Result register
    logic                r_out_valid;
    clcp_pkg::t_status   r_status;
    clcp_pkg::t_target   r_target;
    logic [31:0]         r_value;

    logic                is_nl;
    logic                out_free;
    logic                proc;
    logic                is_digit;
    logic [3:0]          dig;
    logic [35:0]         acc_x10;
    logic [31:0]         acc_sat;

    clcp_pkg::t_status   f_status;
    clcp_pkg::t_target   f_target;
    logic [31:0]         f_value;
    logic [7:0]          body_xor;
    logic [7:0]          sum;
    clcp_pkg::t_hex      h1;
    clcp_pkg::t_hex      h2;
    logic [3:0]          slot;

    // Handshake: a newline needs a free result register
    assign is_nl    = (r_in_byte == clcp_pkg::CH_NL);
    assign out_free = !r_out_valid || o_res.ready;
    assign proc     = r_in_valid && (!is_nl || out_free);
    assign i_rx.ready = !r_in_valid || proc;

    // Capture an input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Digit accumulate: acc * 10 + digit, saturating at all ones
    assign is_digit = (r_in_byte >= clcp_pkg::CH_0) && (r_in_byte <= clcp_pkg::CH_9);
    assign dig      = 4'(r_in_byte - clcp_pkg::CH_0);
    assign acc_x10  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {32'b0, dig};
    assign acc_sat  = (acc_x10[35:32] != 4'b0) ? '1 : acc_x10[31:0];

    // Next line state
    always_comb begin
        n_lpos  = r_lpos;
        n_xor   = r_xor;
        n_acc   = r_acc;
        n_dact  = r_dact;
        n_start = r_start;
        for (int k = 0; k < 3; k++) begin
            n_rb[k]  = r_rb[k];
            n_cmd[k] = r_cmd[k];
        end
        if (proc) begin
            if (is_nl) begin
                n_lpos  = '0;
                n_xor   = '0;
                n_acc   = '0;
                n_dact  = 1'b0;
                n_start = 1'b0;
                for (int k = 0; k < 3; k++) begin
                    n_rb[k]  = '0;
                    n_cmd[k] = '0;
                end
            end else begin
                if (r_lpos == '0) begin
                    n_start = (r_in_byte == clcp_pkg::CH_DOLLAR);
                end else begin
                    n_xor = r_xor ^ r_in_byte;
                end
                for (int k = 0; k < 3; k++) begin
                    if (r_lpos == LW'(k + 1)) begin
                        n_cmd[k] = r_in_byte;
                    end
                end
                if (is_digit) begin
                    if (r_lpos >= LW'(clcp_pkg::POS_FIRST_RUN) &&
                        r_lpos == clcp_pkg::digit_start(r_cmd[0])) begin
                        n_acc  = {28'b0, dig};
                        n_dact = 1'b1;
                    end else if (r_dact) begin
                        n_acc = acc_sat;
                    end
                end else begin
                    n_dact = 1'b0;
                end
                n_rb[0] = r_rb[1];
                n_rb[1] = r_rb[2];
                n_rb[2] = r_in_byte;
                if (r_lpos < LW'(clcp_pkg::MAX_LINE)) begin
                    n_lpos = r_lpos + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpos  <= '0;
            r_xor   <= '0;
            r_acc   <= '0;
            r_dact  <= 1'b0;
            r_start <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_rb[k]  <= '0;
                r_cmd[k] <= '0;
            end
        end else begin
            r_lpos  <= n_lpos;
            r_xor   <= n_xor;
            r_acc   <= n_acc;
            r_dact  <= n_dact;
            r_start <= n_start;
            for (int k = 0; k < 3; k++) begin
                r_rb[k]  <= n_rb[k];
                r_cmd[k] <= n_cmd[k];
            end
        end
    end

    // Line checks and checksum
    assign body_xor = r_xor ^ r_rb[0] ^ r_rb[1] ^ r_rb[2];
    assign h1       = clcp_pkg::hex_value(r_rb[1]);
    assign h2       = clcp_pkg::hex_value(r_rb[2]);
    assign slot     = clcp_pkg::axis_slot(r_cmd[1]);

    always_comb begin
        if (!h1.ok) begin
            sum = '0;
        end else if (h2.ok) begin
            sum = {h1.val, h2.val};
        end else begin
            sum = {4'b0, h1.val};
        end
    end

    // Decode the finished line
    always_comb begin
        f_status = clcp_pkg::ST_OK;
        f_target = clcp_pkg::TGT_NOP;
        f_value  = '0;
        if (r_lpos >= LW'(clcp_pkg::MAX_LINE)) begin
            f_status = clcp_pkg::ST_TOO_LONG;
        end else if (r_lpos < LW'(clcp_pkg::MIN_LINE - 1)) begin
            f_status = clcp_pkg::ST_SHORT;
        end else if (!r_start) begin
            f_status = clcp_pkg::ST_NO_START;
        end else if (r_rb[0] != clcp_pkg::CH_STAR) begin
            f_status = clcp_pkg::ST_NO_STAR;
        end else if (sum != body_xor) begin
            f_status = clcp_pkg::ST_BAD_SUM;
        end

        if (f_status == clcp_pkg::ST_OK) begin
            case (r_cmd[0])
                clcp_pkg::CH_UE: begin
                    if (r_cmd[1] != clcp_pkg::CH_1 && r_cmd[1] != clcp_pkg::CH_2) begin
                        f_status = clcp_pkg::ST_BAD_INDEX;
                    end else if (r_cmd[2] == clcp_pkg::CH_UO) begin
                        f_target = (r_cmd[1] == clcp_pkg::CH_2) ? clcp_pkg::TGT_E_OFS + 5'd2
                                                               : clcp_pkg::TGT_E_OFS;
                    end else if (r_cmd[2] == clcp_pkg::CH_UG) begin
                        f_target = (r_cmd[1] == clcp_pkg::CH_2) ? clcp_pkg::TGT_E_GAIN + 5'd2
                                                               : clcp_pkg::TGT_E_GAIN;
                    end
                end
                clcp_pkg::CH_UX: begin
                    if (slot != clcp_pkg::SLOT_NONE) begin
                        f_target = clcp_pkg::TGT_X_BASE + {1'b0, slot};
                    end
                end
                clcp_pkg::CH_UY: begin
                    if (slot != clcp_pkg::SLOT_NONE) begin
                        f_target = clcp_pkg::TGT_Y_BASE + {1'b0, slot};
                    end
                end
                clcp_pkg::CH_UZ: begin
                    if (r_cmd[1] == clcp_pkg::CH_UE) begin
                        f_target = clcp_pkg::TGT_Z_E;
                    end else if (r_cmd[1] == clcp_pkg::CH_UF) begin
                        f_target = clcp_pkg::TGT_Z_F;
                    end
                end
                clcp_pkg::CH_UO: f_target = clcp_pkg::TGT_OUTPUT;
                clcp_pkg::CH_UW: f_target = clcp_pkg::TGT_SAVE;
                clcp_pkg::CH_UG: f_target = clcp_pkg::TGT_DUMP;
                default:         f_target = clcp_pkg::TGT_NOP;
            endcase
            if (f_target != clcp_pkg::TGT_NOP && f_target <= clcp_pkg::TGT_OUTPUT) begin
                f_value = r_acc;
            end
        end
    end

    // Result register: load on a newline, drop on a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && is_nl) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && is_nl) begin
            r_status <= f_status;
            r_target <= f_target;
            r_value  <= f_value;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_status;
    assign o_res.target = r_target;
    assign o_res.value  = r_value;

    // Checks
    a_lpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lpos <= LW'(clcp_pkg::MAX_LINE))
        else $error("line position beyond limit");

    a_nl_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && is_nl |=> r_lpos == '0 && r_xor == '0 && !r_start)
        else $error("line state not cleared after newline");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != clcp_pkg::ST_OK |-> r_target == '0 && r_value == '0)
        else $error("error result carries target or value");

    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_target == clcp_pkg::TGT_NOP || r_target == clcp_pkg::TGT_SAVE ||
                        r_target == clcp_pkg::TGT_DUMP) |-> r_value == '0)
        else $error("non-data target carries a value");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_rx.ready)
        else $error("input blocked while input register is empty");

endmodule
